// File: hw/rtl/trta_pkg.sv
// Shared constants, register codes and beat types of the rotating transpose address generator.
`timescale 1ns / 1ps
`default_nettype none

package trta_pkg;

    localparam int MAX_DIMS     = 4;
    localparam int INDEX_BITS   = 20;
    localparam int EXT_W        = 16;
    localparam int NUM_EXT_REGS = 4;
    localparam int NDIM_W       = 3;
    localparam int ROT_W        = 2;
    localparam int SLOT_W       = $clog2(MAX_DIMS);
    localparam int DIM_W        = $clog2(MAX_DIMS + 1);
    localparam int TOT_W        = INDEX_BITS + 1;
    localparam int TDATA_W      = ((INDEX_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [TOT_W-1:0] CAPACITY = {1'b1, {INDEX_BITS{1'b0}}};
    localparam logic [TOT_W-1:0] CAP_SAT  = CAPACITY + TOT_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_DIMS = 3'd0,
        CFG_EXTENT_0 = 3'd1,
        CFG_EXTENT_1 = 3'd2,
        CFG_EXTENT_2 = 3'd3,
        CFG_EXTENT_3 = 3'd4,
        CFG_ROTATION = 3'd5
    } trta_cfg_reg_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]            src;
        logic [INDEX_BITS-1:0]            quot;
        logic [MAX_DIMS-1:0][EXT_W-1:0]   coord;
    } trta_item_t;

    typedef struct packed {
        logic       valid;
        trta_item_t item;
    } trta_beat_t;

endpackage

`default_nettype wire

// File: hw/rtl/trta_divmod.sv
// Pipelined restoring divider that peels one coordinate off the running quotient.
`timescale 1ns / 1ps
`default_nettype none

module trta_divmod import trta_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire trta_beat_t        in_beat,
    input  wire logic [EXT_W-1:0]  divisor,
    input  wire logic [SLOT_W-1:0] slot,
    output trta_beat_t             out_beat
);

    localparam int LAST = INDEX_BITS - 1;

    logic             vld_reg  [INDEX_BITS];
    trta_item_t       itm_reg  [INDEX_BITS];
    logic [EXT_W-1:0] rmd_reg  [INDEX_BITS];

    logic             vld_next [INDEX_BITS];
    trta_item_t       itm_next [INDEX_BITS];
    logic [EXT_W-1:0] rmd_next [INDEX_BITS];

    logic             vld_in   [INDEX_BITS];
    trta_item_t       itm_in   [INDEX_BITS];
    logic [EXT_W-1:0] rmd_in   [INDEX_BITS];
    logic [EXT_W:0]   shifted  [INDEX_BITS];
    logic [EXT_W:0]   diff     [INDEX_BITS];
    logic             ge       [INDEX_BITS];

    // Each stage shifts in one dividend bit and produces one quotient bit.
    always_comb begin
        for (int i = 0; i < INDEX_BITS; i++) begin
            if (i == 0) begin
                vld_in[i] = in_beat.valid;
                itm_in[i] = in_beat.item;
                rmd_in[i] = '0;
            end else begin
                vld_in[i] = vld_reg[i-1];
                itm_in[i] = itm_reg[i-1];
                rmd_in[i] = rmd_reg[i-1];
            end
            shifted[i]       = {rmd_in[i], itm_in[i].quot[INDEX_BITS-1]};
            diff[i]          = shifted[i] - {1'b0, divisor};
            ge[i]            = shifted[i] >= {1'b0, divisor};
            rmd_next[i]      = ge[i] ? diff[i][EXT_W-1:0] : shifted[i][EXT_W-1:0];
            itm_next[i]      = itm_in[i];
            itm_next[i].quot = {itm_in[i].quot[INDEX_BITS-2:0], ge[i]};
            vld_next[i]      = vld_in[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < INDEX_BITS; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            for (int i = 0; i < INDEX_BITS; i++) begin
                vld_reg[i] <= vld_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < INDEX_BITS; i++) begin
                itm_reg[i] <= itm_next[i];
                rmd_reg[i] <= rmd_next[i];
            end
        end
    end

    always_comb begin
        out_beat             = '0;
        out_beat.valid       = vld_reg[LAST];
        out_beat.item        = itm_reg[LAST];
        out_beat.item.coord[slot] = rmd_reg[LAST];
    end

endmodule

`default_nettype wire

// File: hw/rtl/tensor_rotate_transpose_address.sv
// Top level of the rotating transpose address generator.
`timescale 1ns / 1ps
`default_nettype none

// The block maps the row-major index of an element of an array with up to four dimensions
// to its row-major index after the axes are rotated cyclically by the rotation register.
// It takes one beat per clock while s_tready is high and returns one beat per input beat,
// in order, through an entry register, three pipelined restoring dividers that resolve one
// quotient bit per stage, a rotation stage, a multiply-add stage for each further dimension
// and an output register. A result flagged out of range carries a zero index. Program the
// registers while no beat is in flight; the derived shape settles after its registers update.
module tensor_rotate_transpose_address import trta_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [TDATA_W-1:0]    s_tdata,    // [19:0] source_index

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [TDATA_W-1:0]         m_tdata,    // [19:0] dest_index
    output logic                       m_tuser,    // [0] out_of_range

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    typedef struct packed {
        logic                           flag;
        logic [INDEX_BITS-1:0]          acc;
        logic [MAX_DIMS-1:0][EXT_W-1:0] nc;
    } trta_hrn_t;

    // Configuration registers.
    logic [NDIM_W-1:0] num_dims_reg;
    logic [EXT_W-1:0]  ext_reg [MAX_DIMS];
    logic [ROT_W-1:0]  rotation_reg;
    trta_cfg_reg_t     cfg_sel;

    assign cfg_ready = 1'b1;
    assign cfg_sel   = trta_cfg_reg_t'(cfg_index);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_dims_reg <= NDIM_W'(1);
            for (int k = 0; k < MAX_DIMS; k++) begin
                ext_reg[k] <= EXT_W'(1);
            end
            rotation_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_sel) inside
                CFG_NUM_DIMS: begin
                    num_dims_reg <= cfg_data[NDIM_W-1:0];
                end
                CFG_EXTENT_0, CFG_EXTENT_1, CFG_EXTENT_2, CFG_EXTENT_3: begin
                    for (int k = 0; k < MAX_DIMS; k++) begin
                        if (k < NUM_EXT_REGS &&
                            cfg_index == CFG_IDX_W'(int'(CFG_EXTENT_0) + k)) begin
                            ext_reg[k] <= cfg_data[EXT_W-1:0];
                        end
                    end
                end
                CFG_ROTATION: begin
                    rotation_reg <= cfg_data[ROT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Shape derived from the registers. Dimensions are right-aligned in the slots, and
    // unused outer slots act as extent one, so the datapath always has MAX_DIMS slots.
    logic [DIM_W-1:0]  n_c;
    logic [DIM_W-1:0]  rot_c;
    logic [DIM_W-1:0]  off_c;
    logic [SLOT_W-1:0] n_s;
    logic [SLOT_W-1:0] rot_s;
    logic [SLOT_W-1:0] off_s;
    logic [SLOT_W-1:0] pos_c [MAX_DIMS];
    logic [EXT_W-1:0]  pe_c  [MAX_DIMS];
    logic [SLOT_W-1:0] sel_c [MAX_DIMS];
    logic [EXT_W-1:0]  ne_c  [MAX_DIMS];

    always_comb begin
        if (num_dims_reg == '0) begin
            n_c = DIM_W'(1);
        end else if (int'(num_dims_reg) > MAX_DIMS) begin
            n_c = DIM_W'(MAX_DIMS);
        end else begin
            n_c = DIM_W'(num_dims_reg);
        end
        rot_c = DIM_W'(rotation_reg);
        for (int i = 0; i < 3; i++) begin
            if (rot_c >= n_c) begin
                rot_c = rot_c - n_c;
            end
        end
        off_c = DIM_W'(MAX_DIMS) - n_c;
        n_s   = n_c[SLOT_W-1:0];
        rot_s = rot_c[SLOT_W-1:0];
        off_s = off_c[SLOT_W-1:0];
        for (int k = 0; k < MAX_DIMS; k++) begin
            pos_c[k] = SLOT_W'(k) - off_s;
            if (k < int'(off_c)) begin
                pe_c[k] = EXT_W'(1);
            end else begin
                pe_c[k] = ext_reg[pos_c[k]];
            end
        end
        for (int k = 0; k < MAX_DIMS; k++) begin
            if (k < int'(off_c)) begin
                sel_c[k] = SLOT_W'(k);
            end else if (pos_c[k] >= rot_s) begin
                sel_c[k] = pos_c[k] - rot_s + off_s;
            end else begin
                sel_c[k] = pos_c[k] - rot_s + n_s + off_s;
            end
            ne_c[k] = pe_c[sel_c[k]];
        end
    end

    logic [EXT_W-1:0]       pe_reg   [MAX_DIMS];
    logic [SLOT_W-1:0]      sel_reg  [MAX_DIMS];
    logic [EXT_W-1:0]       ne_reg   [MAX_DIMS];
    logic [TOT_W-1:0]       tot_reg  [MAX_DIMS];
    logic [TOT_W-1:0]       tot_next [MAX_DIMS];
    logic [TOT_W+EXT_W-1:0] tot_prod [MAX_DIMS];

    // Saturating product of the extents, one multiply per stage.
    always_comb begin
        for (int k = 0; k < MAX_DIMS; k++) begin
            if (k == 0) begin
                tot_prod[k] = (TOT_W + EXT_W)'(pe_reg[k]);
            end else begin
                tot_prod[k] = tot_reg[k-1] * pe_reg[k];
            end
            if (tot_prod[k] > {{EXT_W{1'b0}}, CAPACITY}) begin
                tot_next[k] = CAP_SAT;
            end else begin
                tot_next[k] = tot_prod[k][TOT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_DIMS; k++) begin
            pe_reg[k]  <= pe_c[k];
            sel_reg[k] <= sel_c[k];
            ne_reg[k]  <= ne_c[k];
            tot_reg[k] <= tot_next[k];
        end
    end

    // Pipeline enable; the entry, divider and Horner stages hold only while the skid stage is occupied.
    logic en;
    logic skid_v_reg;

    assign en       = !skid_v_reg;
    assign s_tready = en;

    // Entry stage.
    logic       ent_v_reg;
    trta_item_t ent_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_v_reg <= 1'b0;
        end else if (en) begin
            ent_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ent_item_reg.src   <= s_tdata[INDEX_BITS-1:0];
            ent_item_reg.quot  <= s_tdata[INDEX_BITS-1:0];
            ent_item_reg.coord <= '0;
        end
    end

    // Coordinate extraction, innermost slot first.
    trta_beat_t chain [MAX_DIMS];

    assign chain[0] = '{valid: ent_v_reg, item: ent_item_reg};

    for (genvar j = 0; j < MAX_DIMS - 1; j++) begin : g_div
        trta_divmod u_divmod (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_beat  (chain[j]),
            .divisor  (pe_reg[MAX_DIMS-1-j]),
            .slot     (SLOT_W'(MAX_DIMS - 1 - j)),
            .out_beat (chain[j+1])
        );
    end

    // Rotation and relinearization by Horner steps.
    trta_beat_t                     div_out;
    logic [MAX_DIMS-1:0][EXT_W-1:0] coord_c;
    logic                           hv_reg    [MAX_DIMS];
    trta_hrn_t                      h_reg     [MAX_DIMS];
    logic                           hv_next   [MAX_DIMS];
    trta_hrn_t                      h_next    [MAX_DIMS];
    logic [INDEX_BITS+EXT_W-1:0]    h_prod    [MAX_DIMS];

    assign div_out = chain[MAX_DIMS-1];

    always_comb begin
        coord_c    = div_out.item.coord;
        coord_c[0] = EXT_W'(div_out.item.quot);
        for (int k = 0; k < MAX_DIMS; k++) begin
            h_prod[k] = '0;
            if (k == 0) begin
                hv_next[k] = div_out.valid;
                for (int q = 0; q < MAX_DIMS; q++) begin
                    h_next[k].nc[q] = coord_c[sel_reg[q]];
                end
                h_next[k].acc  = INDEX_BITS'(coord_c[sel_reg[0]]);
                h_next[k].flag = (tot_reg[MAX_DIMS-1] > CAPACITY) ||
                                 ({1'b0, div_out.item.src} >= tot_reg[MAX_DIMS-1]);
            end else begin
                hv_next[k]    = hv_reg[k-1];
                h_prod[k]     = h_reg[k-1].acc * ne_reg[k];
                h_next[k]     = h_reg[k-1];
                h_next[k].acc = h_prod[k][INDEX_BITS-1:0] +
                                INDEX_BITS'(h_reg[k-1].nc[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_DIMS; k++) begin
                hv_reg[k] <= 1'b0;
            end
        end else if (en) begin
            for (int k = 0; k < MAX_DIMS; k++) begin
                hv_reg[k] <= hv_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < MAX_DIMS; k++) begin
                h_reg[k] <= h_next[k];
            end
        end
    end

    // Output register with a one-beat skid stage behind it.
    logic                  ing_v;
    logic [INDEX_BITS-1:0] ing_dest;
    logic                  ing_flag;
    logic                  m_tvalid_reg;
    logic [INDEX_BITS-1:0] m_dest_reg;
    logic                  m_flag_reg;
    logic [INDEX_BITS-1:0] skid_dest_reg;
    logic                  skid_flag_reg;

    assign ing_v    = en && hv_reg[MAX_DIMS-1];
    assign ing_flag = h_reg[MAX_DIMS-1].flag;
    assign ing_dest = ing_flag ? '0 : h_reg[MAX_DIMS-1].acc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            skid_v_reg   <= 1'b0;
        end else if (m_tready || !m_tvalid_reg) begin
            if (skid_v_reg) begin
                m_tvalid_reg <= 1'b1;
                skid_v_reg   <= 1'b0;
            end else begin
                m_tvalid_reg <= ing_v;
            end
        end else if (ing_v) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !m_tvalid_reg) begin
            if (skid_v_reg) begin
                m_dest_reg <= skid_dest_reg;
                m_flag_reg <= skid_flag_reg;
            end else begin
                m_dest_reg <= ing_dest;
                m_flag_reg <= ing_flag;
            end
        end else if (ing_v) begin
            skid_dest_reg <= ing_dest;
            skid_flag_reg <= ing_flag;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(m_dest_reg);
    assign m_tuser  = m_flag_reg;

endmodule

`default_nettype wire

// File: hw/rtl/trta_checker.sv
// Port-level assertions for the rotating transpose address generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module trta_checker import trta_pkg::*; (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [TDATA_W-1:0]    m_tdata,
    input wire logic                  m_tuser
);

    // A flagged beat never carries an address.
    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[INDEX_BITS-1:0] == '0)
        else $error("flagged beat carries a nonzero index");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output beat changed");

    // Input backpressure only follows an output stall.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without an output stall");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output valid or input stalled after reset");

endmodule

bind tensor_rotate_transpose_address trta_checker u_trta_checker (.*);

`default_nettype wire

// File: sim/trta_dest_checker.sv
// Checker that predicts and compares the result beats of the rotating transpose address generator.
`timescale 1ns / 1ps

module trta_dest_checker import trta_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,     // [19:0] source_index

    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [TDATA_W-1:0]    m_tdata,     // [19:0] dest_index
    input  logic                  m_tuser,     // [0] out_of_range

    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    output int                    mismatches,
    output int                    pending
);

    typedef struct {
        logic [INDEX_BITS-1:0] dest;
        logic                  oor;
    } dest_expect_t;

    dest_expect_t          dest_expect_q[$];
    logic [NDIM_W-1:0]     dims_reg;
    logic [EXT_W-1:0]      extent_reg [MAX_DIMS];
    logic [ROT_W-1:0]      rot_reg;

    function automatic void rotate_source_index(input logic [INDEX_BITS-1:0] src,
                                                output logic [INDEX_BITS-1:0] dest,
                                                output logic oor);
        int unsigned       n;
        int unsigned       r;
        int unsigned       p;
        longint unsigned   limit;
        longint unsigned   total;
        longint unsigned   rem;
        longint unsigned   stride;
        longint unsigned   acc;
        longint unsigned   coord [MAX_DIMS];
        longint unsigned   new_ext [MAX_DIMS];
        longint unsigned   new_coord [MAX_DIMS];
        limit = 64'd1 << INDEX_BITS;
        n = (dims_reg == 0) ? 1 : ((dims_reg > MAX_DIMS) ? MAX_DIMS : dims_reg);
        r = rot_reg % n;
        total = 1;
        for (int d = 0; d < n; d++) begin
            total = total * extent_reg[d];
            if (total > limit) total = limit + 1;
        end
        if (total > limit || src >= total) begin
            dest = '0;
            oor = 1'b1;
            return;
        end
        rem = src;
        for (int d = n - 1; d >= 0; d--) begin
            coord[d] = rem % extent_reg[d];
            rem = rem / extent_reg[d];
        end
        for (int d = 0; d < n; d++) begin
            p = (d + r) % n;
            new_ext[p] = extent_reg[d];
            new_coord[p] = coord[d];
        end
        acc = 0;
        stride = 1;
        for (int d = n - 1; d >= 0; d--) begin
            acc = acc + new_coord[d] * stride;
            stride = stride * new_ext[d];
        end
        dest = acc[INDEX_BITS-1:0];
        oor = 1'b0;
    endfunction

    always @(posedge aclk) begin
        dest_expect_t want;
        if (!aresetn) begin
            dims_reg = NDIM_W'(1);
            for (int d = 0; d < MAX_DIMS; d++) extent_reg[d] = EXT_W'(1);
            rot_reg = '0;
            dest_expect_q.delete();
            mismatches = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_NUM_DIMS: dims_reg = cfg_data[NDIM_W-1:0];
                    CFG_EXTENT_0: extent_reg[0] = cfg_data[EXT_W-1:0];
                    CFG_EXTENT_1: extent_reg[1] = cfg_data[EXT_W-1:0];
                    CFG_EXTENT_2: extent_reg[2] = cfg_data[EXT_W-1:0];
                    CFG_EXTENT_3: extent_reg[3] = cfg_data[EXT_W-1:0];
                    CFG_ROTATION: rot_reg = cfg_data[ROT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                rotate_source_index(s_tdata[INDEX_BITS-1:0], want.dest, want.oor);
                dest_expect_q.insert(dest_expect_q.size(), want);
            end
            if (m_tvalid && m_tready) begin
                if (dest_expect_q.size() == 0) begin
                    $error("result beat with no input waiting: dest_index %0d out_of_range %0b",
                           m_tdata[INDEX_BITS-1:0], m_tuser);
                    mismatches++;
                end else begin
                    want = dest_expect_q.pop_front();
                    if (m_tdata[INDEX_BITS-1:0] !== want.dest) begin
                        $error("dest_index mismatch: expected %0d, actual %0d",
                               want.dest, m_tdata[INDEX_BITS-1:0]);
                        mismatches++;
                    end
                    if (m_tuser !== want.oor) begin
                        $error("out_of_range mismatch: expected %0b, actual %0b",
                               want.oor, m_tuser);
                        mismatches++;
                    end
                end
            end
        end
        pending = dest_expect_q.size();
    end

endmodule

// File: sim/tb.sv
// Testbench top that drives the rotating transpose address generator and reports the verdict.
`timescale 1ns / 1ps

module tb;
    import trta_pkg::*;

    localparam int PIPE_DEPTH      = 66;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_PHASES   = 13;
    localparam int ITEMS_PER_PHASE = 150;
    localparam longint unsigned INDEX_SPACE = 64'd1 << INDEX_BITS;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [TDATA_W-1:0]    s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    wire logic             s_tready;
    wire logic             m_tvalid;
    wire logic [TDATA_W-1:0] m_tdata;
    wire logic             m_tuser;
    wire logic             cfg_ready;

    int mismatches;
    int pending;
    int cycle_count = 0;
    int rx_mode     = 0;
    int rx_left     = 0;

    logic [NDIM_W-1:0] shape_dims = NDIM_W'(1);
    logic [EXT_W-1:0]  shape_ext [MAX_DIMS] = '{default: EXT_W'(1)};

    always #5 aclk = ~aclk;

    tensor_rotate_transpose_address dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    trta_dest_checker chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // The receiver switches between steady acceptance and several stall patterns.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    function automatic longint unsigned shape_span();
        int unsigned     n;
        longint unsigned total;
        n = (shape_dims == 0) ? 1 : ((shape_dims > MAX_DIMS) ? MAX_DIMS : shape_dims);
        total = 1;
        for (int d = 0; d < n; d++) begin
            total = total * shape_ext[d];
            if (total > INDEX_SPACE) total = INDEX_SPACE + 1;
        end
        return total;
    endfunction

    function automatic logic [INDEX_BITS-1:0] pick_source(input longint unsigned span);
        int unsigned k;
        k = $urandom_range(0, 15);
        if (k == 0 || span == 0 || span > INDEX_SPACE) return INDEX_BITS'($urandom);
        if (k == 1) return INDEX_BITS'(span - 1);
        if (k == 2 && span < INDEX_SPACE) return INDEX_BITS'(span);
        return INDEX_BITS'($urandom_range(0, 32'(span - 1)));
    endfunction

    task automatic send_source(input logic [INDEX_BITS-1:0] src);
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(src);
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        do @(negedge aclk); while (pending != 0);
        repeat (PIPE_DEPTH + 4) @(negedge aclk);
    endtask

    task automatic program_shape(input logic [CFG_DATA_W-1:0] dims_word,
                                 input logic [EXT_W-1:0] e0, e1, e2, e3,
                                 input logic [CFG_DATA_W-1:0] rot_word,
                                 input bit spare);
        drain_results();
        write_reg(CFG_NUM_DIMS, dims_word);
        write_reg(CFG_EXTENT_0, e0);
        write_reg(CFG_EXTENT_1, e1);
        write_reg(CFG_EXTENT_2, e2);
        write_reg(CFG_EXTENT_3, e3);
        write_reg(CFG_ROTATION, rot_word);
        if (spare) write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7, 16'($urandom));
        cfg_valid <= 1'b0;
        shape_dims = dims_word[NDIM_W-1:0];
        shape_ext[0] = e0;
        shape_ext[1] = e1;
        shape_ext[2] = e2;
        shape_ext[3] = e3;
        // The derived shape settles only after the last write has passed through its registers.
        repeat (8) @(negedge aclk);
    endtask

    task automatic run_random(input int count, input bit bursty);
        longint unsigned span;
        int burst;
        span = shape_span();
        burst = $urandom_range(1, 40);
        for (int i = 0; i < count; i++) begin
            send_source(pick_source(span));
            if (bursty) begin
                burst--;
                if (burst == 0) begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 15)) @(negedge aclk);
                    burst = $urandom_range(1, 40);
                end
            end
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        int unsigned     n_raw;
        int unsigned     n_eff;
        int unsigned     ext_max;
        logic [EXT_W-1:0] ext [MAX_DIMS];

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // Shape left at its reset values: a single element.
        send_source(20'd0);
        send_source(20'd1);
        send_source(20'hFFFFF);
        s_tvalid <= 1'b0;

        program_shape(16'd4, 16'd2, 16'd3, 16'd4, 16'd5, 16'd1, 1'b0);
        send_source(20'd0);
        send_source(20'd119);
        send_source(20'd120);
        send_source(20'd57);
        s_tvalid <= 1'b0;

        program_shape(16'd4, 16'd2, 16'd3, 16'd4, 16'd5, 16'd3, 1'b0);
        send_source(20'd119);
        send_source(20'd1);
        s_tvalid <= 1'b0;

        // Total size exactly at capacity.
        program_shape(16'd2, 16'd1024, 16'd1024, 16'd4, 16'd5, 16'd1, 1'b0);
        send_source(20'hFFFFF);
        send_source(20'h5A5A5);
        s_tvalid <= 1'b0;

        program_shape(16'd2, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd0, 1'b0);
        send_source(20'd0);
        s_tvalid <= 1'b0;

        program_shape(16'd3, 16'd7, 16'd0, 16'd9, 16'd1, 16'd2, 1'b0);
        send_source(20'd0);
        s_tvalid <= 1'b0;

        // A dimension count of zero behaves as one.
        program_shape(16'd0, 16'hFFFF, 16'd3, 16'd3, 16'd3, 16'd3, 1'b0);
        send_source(20'd65534);
        send_source(20'd65535);
        s_tvalid <= 1'b0;

        // A dimension count above four saturates, and writes to unused indexes are dropped.
        program_shape(16'd7, 16'd16, 16'd16, 16'd16, 16'd16, 16'd2, 1'b1);
        send_source(20'd65535);
        send_source(20'd12345);
        s_tvalid <= 1'b0;

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 9))
                0: n_raw = 0;
                1: n_raw = $urandom_range(MAX_DIMS + 1, 7);
                default: n_raw = $urandom_range(1, MAX_DIMS);
            endcase
            n_eff = (n_raw == 0) ? 1 : ((n_raw > MAX_DIMS) ? MAX_DIMS : n_raw);
            case (n_eff)
                1: ext_max = 65535;
                2: ext_max = 1024;
                3: ext_max = 100;
                default: ext_max = 32;
            endcase
            for (int d = 0; d < MAX_DIMS; d++) begin
                case ($urandom_range(0, 29))
                    0: ext[d] = '0;
                    1: ext[d] = 16'hFFFF;
                    2: ext[d] = EXT_W'(ext_max);
                    default: ext[d] = EXT_W'($urandom_range(1, ext_max));
                endcase
            end
            program_shape({13'($urandom), 3'(n_raw)}, ext[0], ext[1], ext[2], ext[3],
                          {14'($urandom), 2'($urandom_range(0, 3))},
                          $urandom_range(0, 3) == 0);
            run_random(ITEMS_PER_PHASE, (p % 4) != 3);
        end

        do @(negedge aclk); while (pending != 0);
        repeat (PIPE_DEPTH + 10) @(negedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
